### src/pdc_pkg.sv
`timescale 1ns / 1ps
package pdc_pkg;
  localparam int unsigned NODE_W = 16;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam logic [31:0] EXPIRY_RESET = 32'd300000;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Search request held while the cell row turns
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] now;
  } probe_t;
endpackage

### src/pdc_cell.sv
`timescale 1ns / 1ps
// One position of the rotating slot row: takes its neighbor's entry on shift.
module pdc_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  pdc_pkg::entry_t nb_ent,
  input  logic nb_vld,
  input  logic wr,
  input  pdc_pkg::entry_t wr_ent,
  output pdc_pkg::entry_t ent,
  output logic vld
);
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift) begin
      vld <= nb_vld;
    end else if (wr) begin
      vld <= 1'b1;
    end
    if (shift) begin
      ent <= nb_ent;
    end else if (wr) begin
      ent <= wr_ent;
    end
  end
endmodule

### src/packet_dedup_cache.sv
`timescale 1ns / 1ps
// Channel | dir | tdata fields (low bit up)                      | tuser
// s_axis  | in  | node_id[15:0] sequence_number[47:16] now_ms[79:48] | -
// m_axis  | out | is_duplicate[0], zero fill to 8 bits           | -
// cfg     | in  | expiry_ms, written when cfg_wr is high           | -
// A request is held in a probe register while the cell row rotates one place
// per cycle through one full turn; slot idx sits in cell 0 where one compare
// checks it, and the full turn puts every entry back in its own slot.
// A duplicate result goes from the scan straight to the output register; a miss
// first passes through a store state that writes the chosen slot.
// Reset (rst, synchronous) clears all slot valid bits and sets expiry to 300000.
// The result waits in an output register; a new request is taken only after
// the previous result has been taken.
module packet_dedup_cache #(
  parameter int unsigned CACHE_ENTRIES = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr,
  input  logic [31:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // node_id, sequence_number, now_ms
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata     // is_duplicate
);
  import pdc_pkg::*;

  localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [1:0] {IDLE, SCAN, STORE, DONE} state_t;

  state_t state;
  logic [31:0] expiry_ms;
  probe_t probe;
  logic [CW-1:0] idx;
  logic have_free;
  logic [IW-1:0] free_slot, old_slot, sel;
  logic [31:0] old_age;
  logic dup;

  logic [CACHE_ENTRIES-1:0] vld_v, wr_v;
  entry_t ent_a [CACHE_ENTRIES];
  entry_t wr_ent;
  logic shift;

  // cell g takes from cell g+1; the last wraps to cell 0
  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    localparam int unsigned NB = (g + 1) % CACHE_ENTRIES;
    pdc_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift),
      .nb_ent(ent_a[NB]), .nb_vld(vld_v[NB]),
      .wr(wr_v[g]), .wr_ent(wr_ent),
      .ent(ent_a[g]), .vld(vld_v[g])
    );
  end

  // compare at the head cell only
  logic [31:0] head_age;
  logic head_expired, head_hit, head_free;
  assign head_age = probe.now - ent_a[0].stamp;
  assign head_expired = head_age > expiry_ms;
  assign head_hit = vld_v[0] && !head_expired &&
                    ent_a[0].node == probe.node && ent_a[0].seq == probe.seq;
  assign head_free = !vld_v[0] || head_expired;

  // scan index = slot now in the head cell
  logic [IW-1:0] cur;
  assign cur = idx[IW-1:0];
  assign sel = have_free ? free_slot : old_slot;
  assign shift = (state == SCAN);
  assign wr_ent = '{node: probe.node, seq: probe.seq, stamp: probe.now};

  always_comb begin
    wr_v = '0;
    if (state == STORE) wr_v[sel] = 1'b1;
  end

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = (state == DONE);
  assign m_axis_tdata = {7'd0, dup};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      expiry_ms <= EXPIRY_RESET;
    end else begin
      if (cfg_wr) expiry_ms <= cfg_data;
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            probe <= '{node: s_axis_tdata[15:0], seq: s_axis_tdata[47:16],
                       now: s_axis_tdata[79:48]};
            idx <= '0;
            have_free <= 1'b0;
            free_slot <= '0;
            old_slot <= '0;
            old_age <= '0;
            dup <= 1'b0;
            state <= SCAN;
          end
        end
        SCAN: begin
          // row always finishes the full turn; a hit freezes the search
          if (!dup) begin
            if (head_hit) begin
              dup <= 1'b1;
            end else begin
              if (head_free && !have_free) begin
                have_free <= 1'b1;
                free_slot <= cur;
              end
              if (!head_free && head_age > old_age) begin
                old_age <= head_age;
                old_slot <= cur;
              end
            end
          end
          if (idx == CW'(CACHE_ENTRIES - 1)) state <= (dup || head_hit) ? DONE : STORE;
          idx <= idx + 1'b1;
        end
        STORE: state <= DONE;
        DONE: if (m_axis_tready) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk) disable iff (rst) $onehot0(wr_v))
    else $error("more than one slot written");
  a_no_shift_write: assert property (@(posedge clk) disable iff (rst)
    shift |-> wr_v == '0) else $error("write during rotation");
  a_store_done: assert property (@(posedge clk) disable iff (rst)
    state == STORE |=> state == DONE && !dup) else $error("store path broken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(dup))
    else $error("result dropped");
`endif
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import pdc_pkg::*;

  localparam int unsigned SLOTS = 128;

  // Mirror of the slot cache; keeps its own copy of expiry and of every slot.
  class dedup_scoreboard;
    logic [NODE_W-1:0] slot_node [SLOTS];
    logic [SEQ_W-1:0]  slot_seq  [SLOTS];
    logic [TIME_W-1:0] slot_time [SLOTS];
    bit                slot_used [SLOTS];
    logic [31:0]       expiry;
    bit                dup_expected [$];
    int                fails;

    function new();
      expiry = EXPIRY_RESET;
      fails = 0;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    // Search, then either report a duplicate or store the pair in the chosen slot.
    function void note_request(logic [NODE_W-1:0] node, logic [SEQ_W-1:0] seq,
                               logic [TIME_W-1:0] now);
      int unsigned free_slot, oldest_slot;
      bit have_free;
      logic [31:0] oldest_age, age;
      bit expired;
      int unsigned target;
      free_slot = 0;
      oldest_slot = 0;
      have_free = 0;
      oldest_age = 0;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (!slot_used[i]) begin
          if (!have_free) begin
            have_free = 1;
            free_slot = i;
          end
          continue;
        end
        age = now - slot_time[i];
        expired = age > expiry;
        if (!expired && slot_node[i] == node && slot_seq[i] == seq) begin
          dup_expected.push_back(1'b1);
          return;
        end
        if (expired && !have_free) begin
          have_free = 1;
          free_slot = i;
        end
        if (age > oldest_age) begin
          oldest_age = age;
          oldest_slot = i;
        end
      end
      target = have_free ? free_slot : oldest_slot;
      slot_node[target] = node;
      slot_seq[target] = seq;
      slot_time[target] = now;
      slot_used[target] = 1;
      dup_expected.push_back(1'b0);
    endfunction

    function void check_result(logic [7:0] data);
      bit want;
      if (dup_expected.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $realtime, data);
        fails++;
        return;
      end
      want = dup_expected.pop_front();
      if (data !== {7'b0, want}) begin
        $display("%0t: is_duplicate mismatch, expected %h got %h", $realtime,
                 {7'b0, want}, data);
        fails++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr = 0;
  logic [31:0] cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [7:0] m_axis_tdata;

  dedup_scoreboard sb = new();

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] now_cur = 0;
  logic [NODE_W-1:0] pool_node [$];
  logic [SEQ_W-1:0]  pool_seq  [$];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  packet_dedup_cache #(.CACHE_ENTRIES(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_wr),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Receiver back-pressure, re-rolled every cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Present one request, with random idle cycles first; returns at the accepting edge.
  task automatic send_request(logic [NODE_W-1:0] node, logic [SEQ_W-1:0] seq,
                              logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {now, seq, node};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(node, seq, now);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 0;
    wait (sb.dup_expected.size() == 0);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_expiry(logic [31:0] value);
    @(negedge clk);
    cfg_wr <= 1;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr <= 0;
    sb.expiry = value;
  endtask

  // Mostly repeats and near-repeats from a small pool so duplicates, expiry and
  // eviction by age all get exercised; the rest is full-range noise.
  task automatic random_request(bit hold_off);
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0] seq;
    int unsigned pick, k;
    pick = $urandom_range(99);
    if (pick < 50 && pool_node.size() > 0) begin
      k = $urandom_range(pool_node.size() - 1);
      node = pool_node[k];
      seq = pool_seq[k];
    end else begin
      node = (pick < 85) ? NODE_W'($urandom_range(7)) : NODE_W'($urandom);
      seq = (pick < 70) ? SEQ_W'($urandom_range(15)) : SEQ_W'($urandom);
      pool_node.push_back(node);
      pool_seq.push_back(seq);
      if (pool_node.size() > 200) begin
        void'(pool_node.pop_front());
        void'(pool_seq.pop_front());
      end
    end
    pick = $urandom_range(99);
    if (pick < 40) now_cur += 0;
    else if (pick < 85) now_cur += $urandom_range(3);
    else if (pick < 92) now_cur += sb.expiry + $urandom_range(2) - 1;
    else if (pick < 96) now_cur -= $urandom_range(1000);  // clock steps back
    else now_cur = $urandom;
    if (hold_off && $urandom_range(19) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 0;
      wait (sb.dup_expected.size() == 0);
    end
    send_request(node, seq, now_cur);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: field extremes, repeats, time wrap and backwards, reset expiry
    send_request('0, '0, '0);
    send_request('0, '0, '0);                      // duplicate
    send_request('1, '1, '1);
    send_request('1, '1, 32'd0);                   // wrapped age 1, still live
    send_request('1, '0, '1);
    send_request('0, '1, 32'd300000);              // age exactly expiry
    send_request('0, '0, 32'd300000);              // age exactly expiry: live
    send_request('0, '0, 32'd300001);              // just past: expired, re-store
    send_request('0, '0, 32'd5);                   // stamp in the future: expired
    send_request(16'h5a5a, 32'ha5a5a5a5, 32'h5a5a5a5a);
    send_request(16'ha5a5, 32'h5a5a5a5a, 32'ha5a5a5a5);
    send_request(16'h5a5a, 32'ha5a5a5a5, 32'h5a5a5a5a);
    drain();

    // Largest expiry: fill past capacity so the oldest slot gets replaced
    write_expiry('1);
    sender_idle_pct = 55;
    for (int i = 0; i < 140; i++) send_request(NODE_W'(i), 32'd7, 32'd1000 + i / 3);
    send_request(16'd139, 32'd7, 32'd2000);        // still cached
    send_request(16'd0, 32'd7, 32'd2000);          // evicted earlier
    for (int i = 0; i < 60; i++) random_request(0);
    drain();

    // Zero expiry, with full drains between some requests
    write_expiry('0);
    sender_idle_pct = 0;
    recv_stall_pct = 55;
    for (int i = 0; i < 200; i++) random_request(1);
    drain();

    write_expiry($urandom_range(1, 40));
    sender_idle_pct = 19;
    recv_stall_pct = 19;
    for (int i = 0; i < 200; i++) random_request(0);
    drain();

    write_expiry(EXPIRY_RESET);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 235; i++) random_request(0);
    drain();

    if (sb.fails == 0) begin
      $display("packet_dedup_cache regression: pass");
    end else begin
      $display("packet_dedup_cache regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("packet_dedup_cache regression: fail");
    $finish;
  end
endmodule

### sim.f
src/pdc_pkg.sv
src/pdc_cell.sv
src/packet_dedup_cache.sv
sim/tb.sv
